// ===== rtl/bms_pkg.sv =====
package bms_pkg;

    // power mode codes
    typedef enum logic [1:0] {
        MODE_NOMINAL  = 2'd0,
        MODE_SAVING   = 2'd1,
        MODE_SURVIVAL = 2'd2
    } mode_t;

    // eps switching actions
    typedef enum logic [2:0] {
        EPS_NONE      = 3'd0,
        EPS_OFF       = 3'd1,
        EPS_ON        = 3'd2,
        EPS_CYCLE     = 3'd3,
        EPS_TIMED_ON  = 3'd4,
        EPS_TIMED_OFF = 3'd5
    } eps_t;

    // backup radio supply actions
    typedef enum logic [1:0] {
        RADIO_NONE = 2'd0,
        RADIO_ON   = 2'd1,
        RADIO_OFF  = 2'd2
    } radio_t;

    // outcome of one policy byte
    typedef enum logic [1:0] {
        VOTE_SAVING    = 2'd0,
        VOTE_HOLD      = 2'd1,
        VOTE_UNDECIDED = 2'd2
    } vote_t;

    // ground command codes
    localparam logic [7:0] CMD_NOMINAL  = 8'h07;
    localparam logic [7:0] CMD_SAVING   = 8'h3C;
    localparam logic [7:0] CMD_SURVIVAL = 8'hF0;

    // configuration register indexes
    localparam logic [2:0] CFG_NOMINAL_TO_SAVING = 3'd0;
    localparam logic [2:0] CFG_TO_SURVIVAL       = 3'd1;
    localparam logic [2:0] CFG_NOMINAL_REVIVAL   = 3'd2;
    localparam logic [2:0] CFG_SURVIVAL_HOLD     = 3'd3;
    localparam logic [2:0] CFG_POLICY_PRIMARY    = 3'd4;
    localparam logic [2:0] CFG_POLICY_BACKUP     = 3'd5;

    // error flag bit positions
    localparam int FLAG_ADC       = 0;
    localparam int FLAG_UNDECIDED = 1;
    localparam int FLAG_DEF_NS    = 2;
    localparam int FLAG_DEF_SS    = 3;
    localparam int FLAG_DEF_NR    = 4;
    localparam int FLAG_DEF_SH    = 5;

    // largest raw value that a sample or a threshold may take
    localparam logic [15:0] RAW_MAX = 16'd1023;

    function automatic logic [3:0] ones8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

    function automatic vote_t vote(input logic [7:0] b);
        vote_t d;
        case (ones8(b)) inside
            [4'd2:4'd4]: d = VOTE_SAVING;
            [4'd5:4'd7]: d = VOTE_HOLD;
            default:     d = VOTE_UNDECIDED;
        endcase
        return d;
    endfunction

    function automatic logic sample_ok(input logic [15:0] s);
        return s inside {[16'd1:RAW_MAX]};
    endfunction

endpackage

// ===== rtl/battery_mode_supervisor.sv =====
// battery mode supervisor
// keeps the power mode (nominal, saving, survival) and answers every input
// word with exactly one result word.
// input channel: in_valid / in_ready with opcode, samples, status lines,
//   command_code and delay_ms. opcode 0 is a measurement, 1 a ground command.
// output channel: out_valid / out_ready with new_mode, error_flags,
//   eps_action, pll_reload, radio_action, action_delay, command_error.
// config port: cfg_we, cfg_index, cfg_data; a write lands at the clock edge
//   at which cfg_we is high. write only while the block is idle.
// result: the result word is registered and valid in the cycle after its input word is taken.
// throughput: one word per cycle while out_ready is high; all decision logic sits between the input
//   ports and the result register, and the mode register updates at accept.
// stall: while out_valid is high and out_ready low, the result holds and
//   in_ready drops; in_ready returns in the cycle the result is taken.
// reset: mode goes to saving, thresholds to 600/500/700/550, policy bytes
//   to 224, no result pending.
module battery_mode_supervisor #(
    parameter int LOWER_LIMIT             = 256,
    parameter int DEFAULT_NOMINAL_SAVING  = 600,
    parameter int DEFAULT_TO_SURVIVAL     = 500,
    parameter int DEFAULT_NOMINAL_REVIVAL = 700,
    parameter int DEFAULT_SURVIVAL_HOLD   = 550
) (
    input  logic        clk,
    input  logic        rst_n,

    // input word
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] first_sample,
    input  logic [15:0] second_sample,
    input  logic        release_done,
    input  logic        obc_dead,
    input  logic        separation_switch_low,
    input  logic        backup_radio_powered,
    input  logic [7:0]  command_code,
    input  logic [15:0] delay_ms,

    // result word
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  new_mode,
    output logic [5:0]  error_flags,
    output logic [2:0]  eps_action,
    output logic        pll_reload,
    output logic [1:0]  radio_action,
    output logic [15:0] action_delay,
    output logic        command_error,

    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [15:0] LOWER_W  = 16'(LOWER_LIMIT);
    localparam logic [15:0] DEF_NS_W = 16'(DEFAULT_NOMINAL_SAVING);
    localparam logic [15:0] DEF_SS_W = 16'(DEFAULT_TO_SURVIVAL);
    localparam logic [15:0] DEF_NR_W = 16'(DEFAULT_NOMINAL_REVIVAL);
    localparam logic [15:0] DEF_SH_W = 16'(DEFAULT_SURVIVAL_HOLD);

    // configuration registers
    logic [15:0] ns_level_reg;
    logic [15:0] ss_level_reg;
    logic [15:0] nr_level_reg;
    logic [15:0] sh_level_reg;
    logic [7:0]  policy_primary_reg;
    logic [7:0]  policy_backup_reg;

    // mode state, also shown as new_mode of the pending result
    bms_pkg::mode_t power_mode_reg;
    bms_pkg::mode_t power_mode_next;

    // result register
    logic           out_valid_reg;
    logic [5:0]     error_flags_reg;
    logic [5:0]     error_flags_next;
    bms_pkg::eps_t  eps_reg;
    bms_pkg::eps_t  eps_next;
    logic           pll_reg;
    logic           pll_next;
    bms_pkg::radio_t radio_reg;
    bms_pkg::radio_t radio_next;
    logic [15:0]    action_delay_reg;
    logic [15:0]    action_delay_next;
    logic           command_error_reg;
    logic           command_error_next;

    logic           accept;

    // sample selection and threshold fallback
    logic           first_ok;
    logic           second_ok;
    logic [15:0]    sample_sel;
    logic           ns_bad, ss_bad, nr_bad, sh_bad;
    logic [15:0]    ns_eff, ss_eff, nr_eff, sh_eff;
    bms_pkg::vote_t vote_primary;
    bms_pkg::vote_t vote_backup;
    bms_pkg::vote_t vote_final;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_level_reg       <= 16'd600;
            ss_level_reg       <= 16'd500;
            nr_level_reg       <= 16'd700;
            sh_level_reg       <= 16'd550;
            policy_primary_reg <= 8'd224;
            policy_backup_reg  <= 8'd224;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bms_pkg::CFG_NOMINAL_TO_SAVING: ns_level_reg       <= cfg_data;
                bms_pkg::CFG_TO_SURVIVAL:       ss_level_reg       <= cfg_data;
                bms_pkg::CFG_NOMINAL_REVIVAL:   nr_level_reg       <= cfg_data;
                bms_pkg::CFG_SURVIVAL_HOLD:     sh_level_reg       <= cfg_data;
                bms_pkg::CFG_POLICY_PRIMARY:    policy_primary_reg <= cfg_data[7:0];
                bms_pkg::CFG_POLICY_BACKUP:     policy_backup_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // first sample wins when it is in range, else the retry reading
    always_comb
    begin
        first_ok   = bms_pkg::sample_ok(first_sample);
        second_ok  = bms_pkg::sample_ok(second_sample);
        sample_sel = first_ok ? first_sample : second_sample;
    end

    // a threshold outside (lower limit, 1023] falls back to its default
    always_comb
    begin
        ns_bad = (ns_level_reg > bms_pkg::RAW_MAX) || (ns_level_reg <= LOWER_W);
        ss_bad = (ss_level_reg > bms_pkg::RAW_MAX) || (ss_level_reg <= LOWER_W);
        nr_bad = (nr_level_reg > bms_pkg::RAW_MAX) || (nr_level_reg <= LOWER_W);
        sh_bad = (sh_level_reg > bms_pkg::RAW_MAX) || (sh_level_reg <= LOWER_W);
        ns_eff = ns_bad ? DEF_NS_W : ns_level_reg;
        ss_eff = ss_bad ? DEF_SS_W : ss_level_reg;
        nr_eff = nr_bad ? DEF_NR_W : nr_level_reg;
        sh_eff = sh_bad ? DEF_SH_W : sh_level_reg;
    end

    // policy vote, backup byte only when the primary cannot decide
    always_comb
    begin
        vote_primary = bms_pkg::vote(policy_primary_reg);
        vote_backup  = bms_pkg::vote(policy_backup_reg);
        vote_final   = (vote_primary == bms_pkg::VOTE_UNDECIDED) ? vote_backup
                                                                 : vote_primary;
    end

    // mode update and actions for one word
    always_comb
    begin
        power_mode_next    = power_mode_reg;
        error_flags_next   = '0;
        eps_next           = bms_pkg::EPS_NONE;
        pll_next           = 1'b0;
        radio_next         = bms_pkg::RADIO_NONE;
        action_delay_next  = '0;
        command_error_next = 1'b0;

        if (opcode)
        begin
            // ground command
            case (command_code)
                bms_pkg::CMD_NOMINAL:
                begin
                    radio_next        = bms_pkg::RADIO_OFF;
                    eps_next          = bms_pkg::EPS_TIMED_ON;
                    pll_next          = 1'b1;
                    power_mode_next   = bms_pkg::MODE_NOMINAL;
                    action_delay_next = delay_ms;
                end
                bms_pkg::CMD_SAVING:
                begin
                    eps_next          = bms_pkg::EPS_OFF;
                    radio_next        = bms_pkg::RADIO_ON;
                    power_mode_next   = bms_pkg::MODE_SAVING;
                    action_delay_next = delay_ms;
                end
                bms_pkg::CMD_SURVIVAL:
                begin
                    eps_next          = bms_pkg::EPS_TIMED_OFF;
                    power_mode_next   = bms_pkg::MODE_SURVIVAL;
                    action_delay_next = delay_ms;
                end
                default:
                begin
                    command_error_next = 1'b1;
                end
            endcase
        end
        else if (!first_ok && !second_ok)
        begin
            // no usable reading: the policy bytes decide
            error_flags_next[bms_pkg::FLAG_ADC]       = 1'b1;
            error_flags_next[bms_pkg::FLAG_UNDECIDED] =
                (vote_final == bms_pkg::VOTE_UNDECIDED);
            if (vote_final != bms_pkg::VOTE_HOLD)
            begin
                eps_next        = bms_pkg::EPS_OFF;
                radio_next      = bms_pkg::RADIO_ON;
                power_mode_next = bms_pkg::MODE_SAVING;
            end
        end
        else
        begin
            error_flags_next[bms_pkg::FLAG_DEF_NS] = ns_bad;
            error_flags_next[bms_pkg::FLAG_DEF_SS] = ss_bad;
            error_flags_next[bms_pkg::FLAG_DEF_NR] = nr_bad;
            error_flags_next[bms_pkg::FLAG_DEF_SH] = sh_bad;
            case (power_mode_reg)
                bms_pkg::MODE_NOMINAL:
                begin
                    if (sample_sel >= ns_eff)
                    begin
                        // deployment done and computer dead: power cycle
                        if (release_done && obc_dead)
                        begin
                            eps_next = bms_pkg::EPS_CYCLE;
                            pll_next = 1'b1;
                        end
                    end
                    else if (sample_sel <= ss_eff)
                    begin
                        eps_next        = bms_pkg::EPS_OFF;
                        power_mode_next = bms_pkg::MODE_SURVIVAL;
                    end
                    else
                    begin
                        eps_next        = bms_pkg::EPS_OFF;
                        radio_next      = bms_pkg::RADIO_ON;
                        power_mode_next = bms_pkg::MODE_SAVING;
                    end
                end
                bms_pkg::MODE_SAVING:
                begin
                    if (sample_sel >= nr_eff)
                    begin
                        radio_next      = bms_pkg::RADIO_OFF;
                        eps_next        = bms_pkg::EPS_ON;
                        pll_next        = 1'b1;
                        power_mode_next = bms_pkg::MODE_NOMINAL;
                    end
                    else if (sample_sel <= ss_eff)
                    begin
                        eps_next        = bms_pkg::EPS_OFF;
                        radio_next      = bms_pkg::RADIO_OFF;
                        power_mode_next = bms_pkg::MODE_SURVIVAL;
                    end
                    else if (separation_switch_low)
                    begin
                        eps_next   = bms_pkg::EPS_OFF;
                        radio_next = bms_pkg::RADIO_ON;
                    end
                end
                bms_pkg::MODE_SURVIVAL:
                begin
                    if (sample_sel >= nr_eff)
                    begin
                        eps_next        = bms_pkg::EPS_ON;
                        pll_next        = 1'b1;
                        power_mode_next = bms_pkg::MODE_NOMINAL;
                    end
                    else if (sample_sel <= sh_eff)
                    begin
                        eps_next = bms_pkg::EPS_OFF;
                        if (backup_radio_powered)
                        begin
                            radio_next = bms_pkg::RADIO_OFF;
                        end
                    end
                    else
                    begin
                        eps_next        = bms_pkg::EPS_OFF;
                        radio_next      = bms_pkg::RADIO_ON;
                        power_mode_next = bms_pkg::MODE_SAVING;
                    end
                end
                default:
                begin
                    // unused mode code holds with no action
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_mode_reg <= bms_pkg::MODE_SAVING;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                power_mode_reg <= power_mode_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            error_flags_reg   <= error_flags_next;
            eps_reg           <= eps_next;
            pll_reg           <= pll_next;
            radio_reg         <= radio_next;
            action_delay_reg  <= action_delay_next;
            command_error_reg <= command_error_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_mode      = power_mode_reg;
    assign error_flags   = error_flags_reg;
    assign eps_action    = eps_reg;
    assign pll_reload    = pll_reg;
    assign radio_action  = radio_reg;
    assign action_delay  = action_delay_reg;
    assign command_error = command_error_reg;

    // every accepted word shows up as a result in the next cycle
    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg
    ) else $error("accepted word produced no result");

    // rejected command leaves no action or flag behind
    a_cmd_error_quiet: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && command_error_reg) |->
            (error_flags_reg == 6'd0 && eps_reg == bms_pkg::EPS_NONE &&
             !pll_reg && radio_reg == bms_pkg::RADIO_NONE &&
             action_delay_reg == 16'd0)
    ) else $error("command error with side actions");

    // undecided policy only arises together with an adc error
    a_undecided_needs_adc: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && error_flags_reg[bms_pkg::FLAG_UNDECIDED]) |->
            error_flags_reg[bms_pkg::FLAG_ADC]
    ) else $error("undecided flag without adc error");

    // adc error skips the threshold check, so no default flags
    a_adc_no_defaults: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && error_flags_reg[bms_pkg::FLAG_ADC]) |->
            (error_flags_reg[5:2] == 4'd0)
    ) else $error("default flags set with adc error");

    // a nonzero delay only comes with a commanded eps action
    a_delay_only_cmd: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && action_delay_reg != 16'd0) |->
            (eps_reg == bms_pkg::EPS_TIMED_ON || eps_reg == bms_pkg::EPS_OFF ||
             eps_reg == bms_pkg::EPS_TIMED_OFF)
    ) else $error("action delay on a measurement result");

endmodule

// ===== dv/battery_mode_supervisor_tb.sv =====
module battery_mode_supervisor_tb;

    // threshold fallbacks, handed to the block so both sides agree
    localparam int LOWER_LIMIT             = 256;
    localparam int DEFAULT_NOMINAL_SAVING  = 600;
    localparam int DEFAULT_TO_SURVIVAL     = 500;
    localparam int DEFAULT_NOMINAL_REVIVAL = 700;
    localparam int DEFAULT_SURVIVAL_HOLD   = 550;

    // cycles without any handshake before the run is declared hung
    localparam int unsigned STUCK_LIMIT = 1000;
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 200;

    // one input word as the sender sees it
    typedef struct packed {
        logic        opcode;
        logic [15:0] first_sample;
        logic [15:0] second_sample;
        logic        release_done;
        logic        obc_dead;
        logic        separation_switch_low;
        logic        backup_radio_powered;
        logic [7:0]  command_code;
        logic [15:0] delay_ms;
    } in_word_t;

    // one result word
    typedef struct packed {
        bms_pkg::mode_t  new_mode;
        logic [5:0]      error_flags;
        bms_pkg::eps_t   eps_action;
        logic            pll_reload;
        bms_pkg::radio_t radio_action;
        logic [15:0]     action_delay;
        logic            command_error;
    } outcome_t;

    // mirrors the mode register and the six config registers, predicts the
    // result of every accepted word and checks results in order
    class mode_outcome_board;
        bms_pkg::mode_t power_mode;
        logic [15:0] ns_level;
        logic [15:0] ss_level;
        logic [15:0] nr_level;
        logic [15:0] sh_level;
        logic [7:0]  policy_primary;
        logic [7:0]  policy_backup;
        outcome_t    expected_outcomes[$];
        int unsigned fail_count;

        function new();
            // register reset values
            power_mode     = bms_pkg::MODE_SAVING;
            ns_level       = 16'd600;
            ss_level       = 16'd500;
            nr_level       = 16'd700;
            sh_level       = 16'd550;
            policy_primary = 8'd224;
            policy_backup  = 8'd224;
            fail_count     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                bms_pkg::CFG_NOMINAL_TO_SAVING: ns_level = data;
                bms_pkg::CFG_TO_SURVIVAL:       ss_level = data;
                bms_pkg::CFG_NOMINAL_REVIVAL:   nr_level = data;
                bms_pkg::CFG_SURVIVAL_HOLD:     sh_level = data;
                bms_pkg::CFG_POLICY_PRIMARY:    policy_primary = data[7:0];
                bms_pkg::CFG_POLICY_BACKUP:     policy_backup = data[7:0];
                default: ;
            endcase
        endfunction

        function bms_pkg::vote_t policy_vote(logic [7:0] b);
            int n;
            n = $countones(b);
            if (n >= 2 && n <= 4)
            begin
                return bms_pkg::VOTE_SAVING;
            end
            if (n >= 5 && n <= 7)
            begin
                return bms_pkg::VOTE_HOLD;
            end
            return bms_pkg::VOTE_UNDECIDED;
        endfunction

        // out-of-range threshold falls back to its default and raises its flag
        function logic [15:0] usable_level(logic [15:0] raw, int dflt, int flag_bit,
                                           inout logic [5:0] flags);
            if (raw > bms_pkg::RAW_MAX || raw <= 16'(LOWER_LIMIT))
            begin
                flags[flag_bit] = 1'b1;
                return 16'(dflt);
            end
            return raw;
        endfunction

        function outcome_t next_outcome(in_word_t w);
            outcome_t       r;
            logic [15:0]    v;
            logic [15:0]    ns;
            logic [15:0]    ss;
            logic [15:0]    nr;
            logic [15:0]    sh;
            logic [5:0]     flags;
            bit             ok;
            bms_pkg::vote_t d;
            r.new_mode      = power_mode;
            r.error_flags   = '0;
            r.eps_action    = bms_pkg::EPS_NONE;
            r.pll_reload    = 1'b0;
            r.radio_action  = bms_pkg::RADIO_NONE;
            r.action_delay  = '0;
            r.command_error = 1'b0;
            flags = '0;
            if (w.opcode)
            begin
                case (w.command_code)
                    bms_pkg::CMD_NOMINAL:
                    begin
                        r.new_mode     = bms_pkg::MODE_NOMINAL;
                        r.eps_action   = bms_pkg::EPS_TIMED_ON;
                        r.pll_reload   = 1'b1;
                        r.radio_action = bms_pkg::RADIO_OFF;
                        r.action_delay = w.delay_ms;
                    end
                    bms_pkg::CMD_SAVING:
                    begin
                        r.new_mode     = bms_pkg::MODE_SAVING;
                        r.eps_action   = bms_pkg::EPS_OFF;
                        r.radio_action = bms_pkg::RADIO_ON;
                        r.action_delay = w.delay_ms;
                    end
                    bms_pkg::CMD_SURVIVAL:
                    begin
                        r.new_mode     = bms_pkg::MODE_SURVIVAL;
                        r.eps_action   = bms_pkg::EPS_TIMED_OFF;
                        r.action_delay = w.delay_ms;
                    end
                    default: r.command_error = 1'b1;
                endcase
            end
            else
            begin
                // retry reading only counts when the first one is unusable
                v  = w.first_sample;
                ok = (v != 16'd0) && (v <= bms_pkg::RAW_MAX);
                if (!ok)
                begin
                    v  = w.second_sample;
                    ok = (v != 16'd0) && (v <= bms_pkg::RAW_MAX);
                end
                if (!ok)
                begin
                    flags[bms_pkg::FLAG_ADC] = 1'b1;
                    d = policy_vote(policy_primary);
                    if (d == bms_pkg::VOTE_UNDECIDED)
                    begin
                        d = policy_vote(policy_backup);
                    end
                    if (d == bms_pkg::VOTE_UNDECIDED)
                    begin
                        flags[bms_pkg::FLAG_UNDECIDED] = 1'b1;
                    end
                    if (d != bms_pkg::VOTE_HOLD)
                    begin
                        r.new_mode     = bms_pkg::MODE_SAVING;
                        r.eps_action   = bms_pkg::EPS_OFF;
                        r.radio_action = bms_pkg::RADIO_ON;
                    end
                end
                else
                begin
                    ns = usable_level(ns_level, DEFAULT_NOMINAL_SAVING,
                                      bms_pkg::FLAG_DEF_NS, flags);
                    ss = usable_level(ss_level, DEFAULT_TO_SURVIVAL,
                                      bms_pkg::FLAG_DEF_SS, flags);
                    nr = usable_level(nr_level, DEFAULT_NOMINAL_REVIVAL,
                                      bms_pkg::FLAG_DEF_NR, flags);
                    sh = usable_level(sh_level, DEFAULT_SURVIVAL_HOLD,
                                      bms_pkg::FLAG_DEF_SH, flags);
                    case (power_mode)
                        bms_pkg::MODE_NOMINAL:
                        begin
                            if (v >= ns)
                            begin
                                if (w.release_done && w.obc_dead)
                                begin
                                    r.eps_action = bms_pkg::EPS_CYCLE;
                                    r.pll_reload = 1'b1;
                                end
                            end
                            else if (v <= ss)
                            begin
                                r.eps_action = bms_pkg::EPS_OFF;
                                r.new_mode   = bms_pkg::MODE_SURVIVAL;
                            end
                            else
                            begin
                                r.eps_action   = bms_pkg::EPS_OFF;
                                r.radio_action = bms_pkg::RADIO_ON;
                                r.new_mode     = bms_pkg::MODE_SAVING;
                            end
                        end
                        bms_pkg::MODE_SAVING:
                        begin
                            if (v >= nr)
                            begin
                                r.radio_action = bms_pkg::RADIO_OFF;
                                r.eps_action   = bms_pkg::EPS_ON;
                                r.pll_reload   = 1'b1;
                                r.new_mode     = bms_pkg::MODE_NOMINAL;
                            end
                            else if (v <= ss)
                            begin
                                r.eps_action   = bms_pkg::EPS_OFF;
                                r.radio_action = bms_pkg::RADIO_OFF;
                                r.new_mode     = bms_pkg::MODE_SURVIVAL;
                            end
                            else if (w.separation_switch_low)
                            begin
                                r.eps_action   = bms_pkg::EPS_OFF;
                                r.radio_action = bms_pkg::RADIO_ON;
                            end
                        end
                        bms_pkg::MODE_SURVIVAL:
                        begin
                            if (v >= nr)
                            begin
                                r.eps_action = bms_pkg::EPS_ON;
                                r.pll_reload = 1'b1;
                                r.new_mode   = bms_pkg::MODE_NOMINAL;
                            end
                            else if (v <= sh)
                            begin
                                r.eps_action = bms_pkg::EPS_OFF;
                                if (w.backup_radio_powered)
                                begin
                                    r.radio_action = bms_pkg::RADIO_OFF;
                                end
                            end
                            else
                            begin
                                r.eps_action   = bms_pkg::EPS_OFF;
                                r.radio_action = bms_pkg::RADIO_ON;
                                r.new_mode     = bms_pkg::MODE_SAVING;
                            end
                        end
                        default: ;
                    endcase
                end
                r.error_flags = flags;
            end
            power_mode = r.new_mode;
            return r;
        endfunction

        function void note_word(in_word_t w);
            expected_outcomes.push_back(next_outcome(w));
        endfunction

        function void check_word(outcome_t got);
            outcome_t exp_r;
            if (expected_outcomes.size() == 0)
            begin
                $error("result word with no input word pending");
                fail_count++;
                return;
            end
            exp_r = expected_outcomes.pop_front();
            if (got.new_mode !== exp_r.new_mode)
            begin
                $error("new_mode: expected %0d, got %0d", exp_r.new_mode, got.new_mode);
                fail_count++;
            end
            if (got.error_flags !== exp_r.error_flags)
            begin
                $error("error_flags: expected %0h, got %0h",
                       exp_r.error_flags, got.error_flags);
                fail_count++;
            end
            if (got.eps_action !== exp_r.eps_action)
            begin
                $error("eps_action: expected %0d, got %0d",
                       exp_r.eps_action, got.eps_action);
                fail_count++;
            end
            if (got.pll_reload !== exp_r.pll_reload)
            begin
                $error("pll_reload: expected %0d, got %0d",
                       exp_r.pll_reload, got.pll_reload);
                fail_count++;
            end
            if (got.radio_action !== exp_r.radio_action)
            begin
                $error("radio_action: expected %0d, got %0d",
                       exp_r.radio_action, got.radio_action);
                fail_count++;
            end
            if (got.action_delay !== exp_r.action_delay)
            begin
                $error("action_delay: expected %0d, got %0d",
                       exp_r.action_delay, got.action_delay);
                fail_count++;
            end
            if (got.command_error !== exp_r.command_error)
            begin
                $error("command_error: expected %0d, got %0d",
                       exp_r.command_error, got.command_error);
                fail_count++;
            end
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel, all driven known from time zero
    logic        in_valid              = 1'b0;
    logic        in_ready;
    logic        opcode                = 1'b0;
    logic [15:0] first_sample          = '0;
    logic [15:0] second_sample         = '0;
    logic        release_done          = 1'b0;
    logic        obc_dead              = 1'b0;
    logic        separation_switch_low = 1'b0;
    logic        backup_radio_powered  = 1'b0;
    logic [7:0]  command_code          = '0;
    logic [15:0] delay_ms              = '0;

    // result channel
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  new_mode;
    logic [5:0]  error_flags;
    logic [2:0]  eps_action;
    logic        pll_reload;
    logic [1:0]  radio_action;
    logic [15:0] action_delay;
    logic        command_error;

    // config write port
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // when set, that side never idles
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;

    int unsigned stuck_cycles = 0;

    mode_outcome_board tracker = new();

    battery_mode_supervisor #(
        .LOWER_LIMIT             (LOWER_LIMIT),
        .DEFAULT_NOMINAL_SAVING  (DEFAULT_NOMINAL_SAVING),
        .DEFAULT_TO_SURVIVAL     (DEFAULT_TO_SURVIVAL),
        .DEFAULT_NOMINAL_REVIVAL (DEFAULT_NOMINAL_REVIVAL),
        .DEFAULT_SURVIVAL_HOLD   (DEFAULT_SURVIVAL_HOLD)
    ) uut (.*);

    always #6 clk = ~clk;

    // receiver drops ready about 9 times in 100 unless told to keep up
    always @(negedge clk)
    begin
        out_ready <= receiver_steady || ($urandom_range(99) >= 9);
    end

    // monitor: values read here are the ones settled before the edge, so the
    // result of an older word is checked before the new word is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                tracker.check_word('{new_mode: bms_pkg::mode_t'(new_mode),
                                     error_flags: error_flags,
                                     eps_action: bms_pkg::eps_t'(eps_action),
                                     pll_reload: pll_reload,
                                     radio_action: bms_pkg::radio_t'(radio_action),
                                     action_delay: action_delay,
                                     command_error: command_error});
            end
            if (in_valid && in_ready)
            begin
                tracker.note_word('{opcode: opcode,
                                    first_sample: first_sample,
                                    second_sample: second_sample,
                                    release_done: release_done,
                                    obc_dead: obc_dead,
                                    separation_switch_low: separation_switch_low,
                                    backup_radio_powered: backup_radio_powered,
                                    command_code: command_code,
                                    delay_ms: delay_ms});
            end
        end
    end

    // watchdog: too long without any word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the caller either offers the next word or
    // drops valid at that same edge
    task automatic send_word(input in_word_t w);
        while (!sender_steady && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid              <= 1'b1;
        opcode                <= w.opcode;
        first_sample          <= w.first_sample;
        second_sample         <= w.second_sample;
        release_done          <= w.release_done;
        obc_dead              <= w.obc_dead;
        separation_switch_low <= w.separation_switch_low;
        backup_radio_powered  <= w.backup_radio_powered;
        command_code          <= w.command_code;
        delay_ms              <= w.delay_ms;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    // stop sending and wait for every outstanding result word
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.expected_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        // a little margin after the last result word is checked
        repeat (2) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        tracker.set_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // policy bytes go out with junk in the upper half, which must be ignored
    task automatic apply_setting(input logic [15:0] ns, input logic [15:0] ss,
                                 input logic [15:0] nr, input logic [15:0] sh,
                                 input logic [7:0] pp, input logic [7:0] pb);
        write_reg(bms_pkg::CFG_NOMINAL_TO_SAVING, ns);
        write_reg(bms_pkg::CFG_TO_SURVIVAL, ss);
        write_reg(bms_pkg::CFG_NOMINAL_REVIVAL, nr);
        write_reg(bms_pkg::CFG_SURVIVAL_HOLD, sh);
        write_reg(bms_pkg::CFG_POLICY_PRIMARY, {8'($urandom), pp});
        write_reg(bms_pkg::CFG_POLICY_BACKUP, {8'($urandom), pb});
    endtask

    function automatic in_word_t measure_word(logic [15:0] s1, logic [15:0] s2,
                                              logic rel, logic dead, logic sep,
                                              logic rpw);
        return '{opcode: 1'b0, first_sample: s1, second_sample: s2,
                 release_done: rel, obc_dead: dead, separation_switch_low: sep,
                 backup_radio_powered: rpw, command_code: 8'($urandom),
                 delay_ms: 16'($urandom)};
    endfunction

    function automatic in_word_t command_word(logic [7:0] code, logic [15:0] dly);
        in_word_t w;
        w = in_word_t'({$urandom, $urandom, $urandom});
        w.opcode       = 1'b1;
        w.command_code = code;
        w.delay_ms     = dly;
        return w;
    endfunction

    // samples cluster around the thresholds so the mode keeps moving,
    // with zeros and out-of-range values mixed in
    function automatic logic [15:0] rand_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
        begin
            return 16'($urandom_range(420, 780));
        end
        if (roll < 75)
        begin
            return 16'($urandom_range(1, 1023));
        end
        if (roll < 80)
        begin
            return 16'd0;
        end
        if (roll < 90)
        begin
            return 16'($urandom_range(1024, 65535));
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_level();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'(LOWER_LIMIT);
            2: return 16'd1024;
            3: return 16'($urandom);
            default: return 16'($urandom_range(LOWER_LIMIT + 1, 1023));
        endcase
    endfunction

    function automatic logic [7:0] rand_policy();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w = in_word_t'({$urandom, $urandom, $urandom});
        w.opcode = ($urandom_range(99) < 15);
        if (w.opcode)
        begin
            // mostly known commands, sometimes garbage codes
            case ($urandom_range(9))
                0, 1, 2: w.command_code = bms_pkg::CMD_NOMINAL;
                3, 4:    w.command_code = bms_pkg::CMD_SAVING;
                5, 6:    w.command_code = bms_pkg::CMD_SURVIVAL;
                default: w.command_code = 8'($urandom);
            endcase
        end
        else
        begin
            w.first_sample  = rand_sample();
            w.second_sample = rand_sample();
        end
        return w;
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed walk through the hysteresis tree, starting from saving
        // both samples invalid, default policy byte forces saving
        send_word(measure_word(16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        // first sample too large, retry reading used: saving to nominal
        send_word(measure_word(16'hFFFF, 16'd1023, 1'b0, 1'b0, 1'b0, 1'b0));
        // nominal at threshold with release done and computer dead: power cycle
        send_word(measure_word(16'd600, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
        // nominal just below threshold: to saving
        send_word(measure_word(16'd599, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0));
        // saving in the band with separation switch low
        send_word(measure_word(16'd600, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0));
        // saving in the band, nothing to do
        send_word(measure_word(16'd600, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1));
        // saving down to survival at threshold
        send_word(measure_word(16'd500, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        // survival hold with backup radio powered, then without
        send_word(measure_word(16'd550, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_word(measure_word(16'd550, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0));
        // survival just above hold: back to saving
        send_word(measure_word(16'd551, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        // saving revives to nominal at threshold
        send_word(measure_word(16'd700, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        // smallest valid sample: nominal straight to survival
        send_word(measure_word(16'd1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0));
        // survival revives to nominal
        send_word(measure_word(16'd700, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        // both samples out of range above the top
        send_word(measure_word(16'd1024, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
        // every command, delay extremes, unknown codes
        send_word(command_word(bms_pkg::CMD_SURVIVAL, 16'hFFFF));
        send_word(command_word(bms_pkg::CMD_NOMINAL, 16'd0));
        send_word(command_word(bms_pkg::CMD_SAVING, 16'h1234));
        send_word(command_word(8'hFF, 16'hFFFF));
        send_word(command_word(8'h00, 16'h5555));
        send_word(command_word(8'h06, 16'hAAAA));
        send_word(command_word(bms_pkg::CMD_NOMINAL, 16'hFFFF));

        // random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0: ;
                // every threshold low and bad, both policies undecided
                1: apply_setting(16'd0, 16'(LOWER_LIMIT), 16'd0, 16'(LOWER_LIMIT),
                                 8'h00, 8'h00);
                // every threshold high and bad, both policies undecided
                2: apply_setting(16'hFFFF, 16'd1024, 16'hFFFF, 16'd1024, 8'hFF, 8'hFF);
                // valid extremes; primary holds
                3: apply_setting(16'(LOWER_LIMIT + 1), 16'd1023, 16'd1023,
                                 16'(LOWER_LIMIT + 1), 8'h7F, 8'h01);
                // primary undecided, backup forces saving
                4: apply_setting(16'd800, 16'd300, 16'd900, 16'd400, 8'h01, 8'h03);
                // primary undecided, backup holds
                5: apply_setting(16'd650, 16'd450, 16'd750, 16'd500, 8'hFF, 8'h1F);
                default: apply_setting(rand_level(), rand_level(), rand_level(),
                                       rand_level(), rand_policy(), rand_policy());
            endcase
            // one long stretch with both sides at full rate
            sender_steady   = (phase == 2);
            receiver_steady = (phase == 2);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // hold the sender until the result side has caught up
                if (phase == 6 && n == WORDS_PER_PHASE / 2)
                begin
                    drain_results();
                end
                send_word(random_word());
            end
        end

        drain_results();
        if (tracker.fail_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
